### rtl/ucep_pkg.sv
`timescale 1ns / 1ps

package ucep_pkg;

  // Largest packet of the control endpoint, in bytes.
  localparam int MaxPacket = 64;
  localparam logic [6:0] MaxPktLen = 7'(MaxPacket);

  // Buffer offset of the OUT data buffer after a receive error.
  localparam logic [6:0] OutErrBufOfs = 7'd64;

  // Depth of the queue between the decoder and the sequencer.
  localparam int QDepth = 2;
  localparam int QPtrW = (QDepth > 1) ? $clog2(QDepth) : 1;

  // Buffer event codes.
  localparam logic [2:0] ActSetup    = 3'd0;
  localparam logic [2:0] ActSetupErr = 3'd1;
  localparam logic [2:0] ActOutDone  = 3'd2;
  localparam logic [2:0] ActOutErr   = 3'd3;
  localparam logic [2:0] ActInDone   = 3'd4;

  // Standard requests and descriptor types.
  localparam logic [7:0] ReqSetAddress = 8'd5;
  localparam logic [7:0] ReqGetDesc    = 8'd6;
  localparam logic [7:0] ReqSetConfig  = 8'd9;
  localparam logic [7:0] DescDevice    = 8'd1;
  localparam logic [7:0] DescConfig    = 8'd2;
  localparam logic [7:0] DescString    = 8'd3;

  // Anomaly codes.
  localparam logic [1:0] AnomNone     = 2'd0;
  localparam logic [1:0] AnomData     = 2'd1;
  localparam logic [1:0] AnomNonZlp   = 2'd2;
  localparam logic [1:0] AnomSetupBsy = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_DATA_IN    = 3'd1,
    ST_DATA_OUT   = 3'd2,
    ST_STATUS_IN  = 3'd3,
    ST_STATUS_OUT = 3'd4
  } stage_e;

  typedef enum logic [2:0] {
    K_SETUP,
    K_SETUP_ERR,
    K_OUT_DONE,
    K_OUT_ERR,
    K_IN_DONE,
    K_NONE
  } kind_e;

  // Decoded event as it waits in the queue.
  typedef struct packed {
    kind_e       kind;
    logic        dir_in;
    logic        req_ok;
    logic        stall_out;
    logic [15:0] xlen;
    logic        plen_two;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic        in_arm;
    logic        in_stall;
    logic [6:0]  in_len;
    logic [15:0] in_src_offset;
    logic        out_arm;
    logic        out_stall;
    logic [6:0]  out_buf_offset;
    logic [6:0]  out_len;
    logic        setup_rearm;
    stage_e      stage;
    logic [1:0]  anomaly;
  } result_t;

endpackage

### rtl/ucep_front.sv
`timescale 1ns / 1ps

module ucep_front (
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [63:0]        s_tdata_i,
  input  logic [2:0]         s_tuser_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output ucep_pkg::cmd_t     push_cmd_o
);

  logic        dir_in;
  logic [7:0]  b_request;
  logic [7:0]  desc_type;
  logic [15:0] w_length;
  logic        desc_found;
  logic [15:0] desc_len;
  logic [9:0]  out_pkt_len;
  logic        type_ok;
  logic        req_ok;
  logic        use_desc;

  assign dir_in      = s_tdata_i[0];
  assign b_request   = s_tdata_i[8:1];
  assign desc_type   = s_tdata_i[16:9];
  assign w_length    = s_tdata_i[32:17];
  assign desc_found  = s_tdata_i[33];
  assign desc_len    = s_tdata_i[49:34];
  assign out_pkt_len = s_tdata_i[59:50];

  assign type_ok = (desc_type == ucep_pkg::DescDevice) ||
                   (desc_type == ucep_pkg::DescConfig) ||
                   (desc_type == ucep_pkg::DescString);

  always_comb begin
    req_ok   = 1'b0;
    use_desc = 1'b0;
    unique case (b_request) inside
      ucep_pkg::ReqSetAddress, ucep_pkg::ReqSetConfig: begin
        req_ok = 1'b1;
      end
      ucep_pkg::ReqGetDesc: begin
        req_ok   = type_ok && desc_found;
        use_desc = type_ok && desc_found;
      end
      default: begin
        req_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    push_cmd_o.dir_in    = dir_in;
    push_cmd_o.req_ok    = req_ok;
    push_cmd_o.stall_out = !dir_in && (w_length != 16'd0);
    push_cmd_o.plen_two  = (out_pkt_len == 10'd2);
    // A found descriptor is cut to the length the host asked for.
    push_cmd_o.xlen      = (use_desc && (desc_len < w_length)) ? desc_len : w_length;
    unique case (s_tuser_i)
      ucep_pkg::ActSetup:    push_cmd_o.kind = ucep_pkg::K_SETUP;
      ucep_pkg::ActSetupErr: push_cmd_o.kind = ucep_pkg::K_SETUP_ERR;
      ucep_pkg::ActOutDone:  push_cmd_o.kind = ucep_pkg::K_OUT_DONE;
      ucep_pkg::ActOutErr:   push_cmd_o.kind = ucep_pkg::K_OUT_ERR;
      ucep_pkg::ActInDone:   push_cmd_o.kind = ucep_pkg::K_IN_DONE;
      default:               push_cmd_o.kind = ucep_pkg::K_NONE;
    endcase
  end

  assign push_valid_o = s_tvalid_i;
  assign s_tready_o   = push_ready_i;

endmodule

### rtl/ucep_queue.sv
`timescale 1ns / 1ps

module ucep_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ucep_pkg::cmd_t       push_cmd_i,
  input  logic                 pop_i,
  output ucep_pkg::cmd_t       head_cmd_o,
  output ucep_pkg::q_status_t  status_o
);

  ucep_pkg::cmd_t             entry_q [ucep_pkg::QDepth];
  logic [ucep_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [ucep_pkg::QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [ucep_pkg::QPtrW:0]   count_q, count_d;
  logic                       do_push;
  logic                       do_pop;

  localparam logic [ucep_pkg::QPtrW-1:0] LastPtr = ucep_pkg::QPtrW'(ucep_pkg::QDepth - 1);
  localparam logic [ucep_pkg::QPtrW:0]   FullCnt = (ucep_pkg::QPtrW + 1)'(ucep_pkg::QDepth);

  assign status_o.full  = (count_q == FullCnt);
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_cmd_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### rtl/ucep_back.sv
`timescale 1ns / 1ps

module ucep_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ucep_pkg::cmd_t       head_cmd_i,
  input  ucep_pkg::q_status_t  q_status_i,
  output logic                 pop_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output ucep_pkg::result_t    res_o
);

  ucep_pkg::stage_e  stage_q, stage_d;
  logic [15:0]       len_q, len_d;
  logic [15:0]       ofs_q, ofs_d;
  logic              valid_q, valid_d;
  ucep_pkg::result_t res_q, res_d;

  ucep_pkg::stage_e  base_stage;
  logic [15:0]       base_len;
  logic [15:0]       base_ofs;
  logic [15:0]       left;
  logic [6:0]        chunk;
  logic              do_adv;
  logic              is_setup_ok;

  assign pop_o = !q_status_i.empty && (!valid_q || res_ready_i);

  // A setup that is accepted starts its data stage from offset zero.
  assign is_setup_ok = (head_cmd_i.kind == ucep_pkg::K_SETUP) && head_cmd_i.req_ok;
  assign base_stage  = is_setup_ok ? (head_cmd_i.dir_in ? ucep_pkg::ST_DATA_IN
                                                         : ucep_pkg::ST_DATA_OUT)
                                   : stage_q;
  assign base_len = is_setup_ok ? head_cmd_i.xlen : len_q;
  assign base_ofs = is_setup_ok ? 16'd0 : ofs_q;
  assign left     = base_len - base_ofs;
  assign chunk    = (left > 16'(ucep_pkg::MaxPacket)) ? ucep_pkg::MaxPktLen : left[6:0];

  always_comb begin
    res_d   = '0;
    stage_d = stage_q;
    len_d   = len_q;
    ofs_d   = ofs_q;
    do_adv  = 1'b0;

    case (head_cmd_i.kind)
      ucep_pkg::K_SETUP: begin
        res_d.setup_rearm = 1'b1;
        if (stage_q != ucep_pkg::ST_IDLE) begin
          res_d.anomaly = ucep_pkg::AnomSetupBsy;
        end
        len_d = head_cmd_i.xlen;
        ofs_d = 16'd0;
        if (!head_cmd_i.req_ok) begin
          if (head_cmd_i.stall_out) begin
            stage_d         = ucep_pkg::ST_STATUS_OUT;
            res_d.out_arm   = 1'b1;
            res_d.out_stall = 1'b1;
          end else begin
            stage_d        = ucep_pkg::ST_STATUS_IN;
            res_d.in_arm   = 1'b1;
            res_d.in_stall = 1'b1;
          end
        end else begin
          stage_d = base_stage;
          do_adv  = 1'b1;
        end
      end
      ucep_pkg::K_SETUP_ERR: begin
        res_d.setup_rearm = 1'b1;
      end
      ucep_pkg::K_OUT_DONE: begin
        if (stage_q == ucep_pkg::ST_STATUS_OUT) begin
          if (head_cmd_i.plen_two) begin
            stage_d = ucep_pkg::ST_IDLE;
          end else begin
            res_d.anomaly = ucep_pkg::AnomNonZlp;
          end
        end else if (stage_q == ucep_pkg::ST_DATA_OUT) begin
          do_adv = 1'b1;
        end else begin
          res_d.anomaly = ucep_pkg::AnomData;
        end
      end
      ucep_pkg::K_OUT_ERR: begin
        res_d.out_arm        = 1'b1;
        res_d.out_buf_offset = ucep_pkg::OutErrBufOfs;
        res_d.out_len        = ucep_pkg::MaxPktLen;
      end
      ucep_pkg::K_IN_DONE: begin
        if (stage_q == ucep_pkg::ST_STATUS_IN) begin
          stage_d = ucep_pkg::ST_IDLE;
        end else if (stage_q == ucep_pkg::ST_DATA_IN) begin
          do_adv = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (do_adv) begin
      if (base_stage == ucep_pkg::ST_DATA_IN) begin
        res_d.in_arm        = 1'b1;
        res_d.in_len        = chunk;
        res_d.in_src_offset = base_ofs;
        ofs_d               = base_ofs + 16'(chunk);
        // A short packet ends the data stage; the host then sends the status.
        if (chunk < ucep_pkg::MaxPktLen) begin
          res_d.out_arm = 1'b1;
          stage_d       = ucep_pkg::ST_STATUS_OUT;
        end
      end else if (base_stage == ucep_pkg::ST_DATA_OUT) begin
        if (base_ofs == base_len) begin
          res_d.in_arm = 1'b1;
          stage_d      = ucep_pkg::ST_STATUS_IN;
        end
      end
    end

    res_d.stage = stage_d;

    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (res_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= ucep_pkg::ST_IDLE;
      len_q   <= '0;
      ofs_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (pop_o) begin
        stage_q <= stage_d;
        len_q   <= len_d;
        ofs_q   <= ofs_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### rtl/usb_control_endpoint_sequencer_core.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake                    Payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata: request fields, tuser: buffer event
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata: descriptors to arm, stage, anomaly
//
// One item is taken every cycle while the queue is not full; each gives one result
// item, held first in the queue and then in the output register until it is taken.
// The sequencer step (one subtract, compare and add on 16 bits) is combinational.
// Reset clears the stage, transfer length, offset and the queue; no clearing pass.
// While m_axis stalls, the two-entry queue keeps taking items until it fills.

module usb_control_endpoint_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // dir_in[0], b_request[8:1], desc_type[16:9], w_length[32:17], desc_found[33],
  // desc_len[49:34], out_pkt_len[59:50], zero[63:60]
  input  logic [63:0] s_axis_tdata,
  // action[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // in_arm[0], in_stall[1], in_len[8:2], in_src_offset[24:9], out_arm[25],
  // out_stall[26], out_buf_offset[33:27], out_len[40:34], setup_rearm[41],
  // stage[44:42], anomaly[46:45], zero[47]
  output logic [47:0] m_axis_tdata
);

  logic                push_valid;
  logic                push_ready;
  ucep_pkg::cmd_t      push_cmd;
  ucep_pkg::cmd_t      head_cmd;
  ucep_pkg::q_status_t q_status;
  logic                pop;
  ucep_pkg::result_t   res;

  ucep_front u_front (
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_o   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  assign push_ready = !q_status.full;

  ucep_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_valid),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_cmd_o (head_cmd),
    .status_o   (q_status)
  );

  ucep_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_cmd_i  (head_cmd),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {1'b0, res.anomaly, res.stage, res.setup_rearm, res.out_len,
                         res.out_buf_offset, res.out_stall, res.out_arm, res.in_src_offset,
                         res.in_len, res.in_stall, res.in_arm};

  // An accepted item is held in the queue at the next edge at the latest.
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !q_status.empty)
    else $error("accepted item missing from queue");

  // A stalled descriptor carries no length or offset.
  a_stall_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res.in_stall || res.out_stall) |->
      (res.in_len == '0) && (res.in_src_offset == '0) &&
      (res.out_len == '0) && (res.out_buf_offset == '0))
    else $error("stalled descriptor with length or offset");

  // No IN packet is longer than the largest packet.
  a_in_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.in_len <= ucep_pkg::MaxPktLen)
    else $error("IN length above packet size");

  // Arming IN always belongs to a transfer in progress.
  a_in_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.in_arm |-> res.stage != ucep_pkg::ST_IDLE)
    else $error("IN armed while idle");

endmodule
